[rtl/core/thb_pkg.sv]
// shared types, constants and decode functions for the triggered hit event builder
package thb_pkg;

    localparam int MAX_PENDING_DEF = 32;

    localparam logic [3:0] TYPE_END    = 4'd1;
    localparam logic [3:0] TYPE_HEADER = 4'd2;
    localparam logic [3:0] TYPE_HIT    = 4'd3;

    localparam logic [7:0] COL_MAX    = 8'd131;
    localparam logic [8:0] ROW_FOLD   = 9'd186;
    localparam logic [8:0] ROW_MIRROR = 9'd185;
    localparam logic [8:0] ROW_LIMIT  = 9'd372;

    // one stored hit
    typedef struct packed {
        logic [7:0]  column;
        logic [8:0]  row;
        logic [6:0]  tot_code;
        logic        begin_flag;
        logic [31:0] fine_time;
        logic [39:0] event_time;
        logic [19:0] trigger_number;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

    function automatic logic [6:0] gray_dec7(input logic [6:0] g);
        logic [6:0] b;
        for (int i = 0; i < 7; i++)
        begin
            b[i] = ^(g >> i);
        end
        return b;
    endfunction

    function automatic logic [9:0] gray_dec10(input logic [9:0] g);
        logic [9:0] b;
        for (int i = 0; i < 10; i++)
        begin
            b[i] = ^(g >> i);
        end
        return b;
    endfunction

endpackage

[rtl/core/thb_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module thb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/triggered_hit_event_builder.sv]
// Triggered hit event builder: takes one 64-bit readout word per cycle when not stalled
// (header, hit and end-of-event words; all others, including all-ones empty words, are
// ignored). Valid hits are written into a MAX_PENDING-entry pending ram. An end-of-event
// word, if hits were stored after the first header, starts a drain that reads the ram one
// entry per cycle and emits every such hit, one item per cycle while the output is not
// stalled; input stall stays high while the drain runs, and does not rise when nothing is
// emitted. Hits beyond MAX_PENDING in an event are dropped and flagged as overflowed.
module triggered_hit_event_builder
    import thb_pkg::*;
#(
    parameter int MAX_PENDING = MAX_PENDING_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  column,
    output logic [8:0]  row,
    output logic [6:0]  tot_code,
    output logic [31:0] fine_time,
    output logic        begin_flag,
    output logic [39:0] event_time,
    output logic [19:0] trigger_number,
    output logic [39:0] trigger_time,
    output logic [9:0]  coarse_ts,
    output logic        overflowed,
    output logic        last
);

    localparam int IW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int CW = $clog2(MAX_PENDING + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PENDING);

    state_t        state_reg, state_next;
    logic          header_seen_reg, header_seen_next;
    logic [39:0]   held_time_reg, held_time_next;
    logic [19:0]   held_trig_reg, held_trig_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] hdr_start_reg, hdr_start_next;
    logic          drop_reg, drop_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] end_idx_reg, end_idx_next;
    logic [39:0]   trig_time_reg;
    logic [9:0]    cts_reg;
    logic          ovf_reg;
    logic          out_valid_reg, out_valid_next;
    entry_t        out_entry_reg;
    logic          out_last_reg;
    logic [39:0]   out_trig_reg;
    logic [9:0]    out_cts_reg;
    logic          out_ovf_reg;

    logic          in_fire;
    logic [3:0]    kind;
    logic          is_hdr, is_hit, is_end;
    logic [8:0]    row_inv;
    logic [8:0]    row_fold;
    logic          hit_ok;
    logic          has_room;
    logic          wr_en;
    entry_t        wr_entry;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    entry_t        rd_entry;
    logic          start_drain;
    logic          emit_fire;
    logic          emit_last;
    logic [CW-1:0] count_dec;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign kind     = word[63:60];
    assign is_hdr   = in_fire && (kind == TYPE_HEADER);
    assign is_hit   = in_fire && (kind == TYPE_HIT);
    assign is_end   = in_fire && (kind == TYPE_END);

    // row: invert, then fold the low part back
    assign row_inv  = ~{word[16], word[15:8]};
    assign row_fold = (row_inv < ROW_FOLD) ? (ROW_MIRROR - row_inv) : row_inv;
    assign hit_ok   = (word[7:0] <= COL_MAX) && (row_fold < ROW_LIMIT);
    assign has_room = (count_reg < COUNT_MAX);
    assign wr_en    = is_hit && hit_ok && has_room;

    always_comb
    begin
        wr_entry.column         = COL_MAX - word[7:0];
        wr_entry.row            = row_fold;
        wr_entry.tot_code       = gray_dec7(~word[23:17]);
        wr_entry.begin_flag     = word[59];
        wr_entry.fine_time      = word[55:24];
        wr_entry.event_time     = held_time_reg;
        wr_entry.trigger_number = held_trig_reg;
    end

    assign count_dec   = count_reg - 1'b1;
    assign start_drain = is_end && header_seen_reg && (hdr_start_reg < count_reg);
    assign emit_fire   = (state_reg == S_DRAIN) && (!out_valid_reg || !out_stall);
    assign emit_last   = (idx_reg == end_idx_reg);

    // next read is issued in the same cycle the current ram data is consumed
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg + 1'b1;
        if (start_drain)
        begin
            rd_en   = 1'b1;
            rd_addr = hdr_start_reg[IW-1:0];
        end
        else if (emit_fire && !emit_last)
        begin
            rd_en = 1'b1;
        end
    end

    thb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PENDING)
    ) u_pending (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry = entry_t'(rd_data);

    always_comb
    begin
        state_next       = state_reg;
        header_seen_next = header_seen_reg;
        held_time_next   = held_time_reg;
        held_trig_next   = held_trig_reg;
        count_next       = count_reg;
        hdr_start_next   = hdr_start_reg;
        drop_next        = drop_reg;
        idx_next         = idx_reg;
        end_idx_next     = end_idx_reg;
        out_valid_next   = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (is_hdr)
        begin
            held_time_next   = word[39:0];
            held_trig_next   = word[59:40];
            header_seen_next = 1'b1;
            if (!header_seen_reg)
            begin
                hdr_start_next = count_reg;
            end
        end

        if (is_hit && hit_ok)
        begin
            if (has_room)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                drop_next = 1'b1;
            end
        end

        if (is_end)
        begin
            count_next       = '0;
            hdr_start_next   = '0;
            header_seen_next = 1'b0;
            held_time_next   = '0;
            held_trig_next   = '0;
            drop_next        = 1'b0;
            if (start_drain)
            begin
                state_next   = S_DRAIN;
                idx_next     = hdr_start_reg[IW-1:0];
                end_idx_next = count_dec[IW-1:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
            end
            S_DRAIN:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            header_seen_reg <= 1'b0;
            held_time_reg   <= '0;
            held_trig_reg   <= '0;
            count_reg       <= '0;
            hdr_start_reg   <= '0;
            drop_reg        <= 1'b0;
            idx_reg         <= '0;
            end_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            header_seen_reg <= header_seen_next;
            held_time_reg   <= held_time_next;
            held_trig_reg   <= held_trig_next;
            count_reg       <= count_next;
            hdr_start_reg   <= hdr_start_next;
            drop_reg        <= drop_next;
            idx_reg         <= idx_next;
            end_idx_reg     <= end_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // per-event stamps and the output item
    always_ff @(posedge clk)
    begin
        if (start_drain)
        begin
            trig_time_reg <= {word[57:56], word[55:24], word[23:18]};
            cts_reg       <= gray_dec10(word[9:0]);
            ovf_reg       <= drop_reg;
        end
        if (emit_fire)
        begin
            out_entry_reg <= rd_entry;
            out_last_reg  <= emit_last;
            out_trig_reg  <= trig_time_reg;
            out_cts_reg   <= cts_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign column         = out_entry_reg.column;
    assign row            = out_entry_reg.row;
    assign tot_code       = out_entry_reg.tot_code;
    assign fine_time      = out_entry_reg.fine_time;
    assign begin_flag     = out_entry_reg.begin_flag;
    assign event_time     = out_entry_reg.event_time;
    assign trigger_number = out_entry_reg.trigger_number;
    assign trigger_time   = out_trig_reg;
    assign coarse_ts      = out_cts_reg;
    assign overflowed     = out_ovf_reg;
    assign last           = out_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("pending count above store depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> (idx_reg <= end_idx_reg))
        else $error("drain index past last entry");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        is_end |=> (count_reg == '0) && !header_seen_reg && !drop_reg)
        else $error("end-of-event did not clear the event");

    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && emit_last) |=> (state_reg == S_IDLE) && out_valid_reg && out_last_reg)
        else $error("last item did not close the drain");
`endif

endmodule

[tb/testbench.sv]
// self-checking testbench for the triggered hit event builder
module testbench;
    import thb_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RESULT_LATENCY = 12;
    localparam int PIW            = $clog2(MAX_PENDING_DEF);

    // word types the block does not decode
    localparam logic [3:0] TYPE_NONE = 4'd0;
    localparam logic [3:0] TYPE_TEST = 4'd4;
    localparam logic [3:0] TYPE_FILL = 4'd15;

    // lowest raw row field whose inverted value is still a legal row
    localparam logic [8:0] RAW_ROW_OK = 9'h1FF - ROW_LIMIT + 9'd1;

    typedef struct packed {
        logic [7:0]  column;
        logic [8:0]  row;
        logic [6:0]  tot_code;
        logic        begin_flag;
        logic        after_header;
        logic [31:0] fine_time;
        logic [39:0] event_time;
        logic [19:0] trigger_number;
    } pending_hit_t;

    typedef struct packed {
        logic [7:0]  column;
        logic [8:0]  row;
        logic [6:0]  tot_code;
        logic [31:0] fine_time;
        logic        begin_flag;
        logic [39:0] event_time;
        logic [19:0] trigger_number;
        logic [39:0] trigger_time;
        logic [9:0]  coarse_ts;
        logic        overflowed;
        logic        last;
    } hit_out_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] word;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  column;
    logic [8:0]  row;
    logic [6:0]  tot_code;
    logic [31:0] fine_time;
    logic        begin_flag;
    logic [39:0] event_time;
    logic [19:0] trigger_number;
    logic [39:0] trigger_time;
    logic [9:0]  coarse_ts;
    logic        overflowed;
    logic        last;

    // predictor state
    logic         header_seen;
    logic [39:0]  held_event_time;
    logic [19:0]  held_trigger_number;
    pending_hit_t pending_hits [MAX_PENDING_DEF];
    int           pending_count;
    logic         drop_flag;

    hit_out_t expected_hits [$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int words_used;
    int hits_checked;
    int events_closed;
    int overflow_events;
    int cycle_count;

    triggered_hit_event_builder DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .word           (word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .column         (column),
        .row            (row),
        .tot_code       (tot_code),
        .fine_time      (fine_time),
        .begin_flag     (begin_flag),
        .event_time     (event_time),
        .trigger_number (trigger_number),
        .trigger_time   (trigger_time),
        .coarse_ts      (coarse_ts),
        .overflowed     (overflowed),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[triggered_hit_event_builder] ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [9:0] gray_to_binary(input logic [9:0] g);
        logic [9:0] b;
        b[9] = g[9];
        for (int i = 8; i >= 0; i--)
        begin
            b[i] = b[i + 1] ^ g[i];
        end
        return b;
    endfunction

    function automatic logic [63:0] hit_word(input logic bgn, input logic [31:0] fine,
                                             input logic [6:0] tot_raw,
                                             input logic [8:0] row_raw,
                                             input logic [7:0] col_raw);
        logic [2:0] spare;
        spare = 3'($urandom_range(7));
        return {TYPE_HIT, bgn, spare, fine, tot_raw, row_raw, col_raw};
    endfunction

    function automatic logic [63:0] make_hit(input logic addr_ok);
        logic [7:0] col_raw;
        logic [8:0] row_raw;
        col_raw = 8'($urandom_range(COL_MAX));
        row_raw = 9'($urandom_range(511, RAW_ROW_OK));
        if (!addr_ok)
        begin
            if ($urandom_range(1))
                col_raw = 8'($urandom_range(255, COL_MAX + 1));
            else
                row_raw = 9'($urandom_range(RAW_ROW_OK - 1));
        end
        return hit_word(1'($urandom_range(1)), $urandom, 7'($urandom_range(127)),
                        row_raw, col_raw);
    endfunction

    function automatic logic [63:0] make_header();
        logic [63:0] w;
        w = {$urandom, $urandom};
        w[63:60] = TYPE_HEADER;
        return w;
    endfunction

    function automatic logic [63:0] make_end();
        logic [63:0] w;
        w = {$urandom, $urandom};
        w[63:60] = TYPE_END;
        return w;
    endfunction

    function automatic logic [63:0] make_noise();
        logic [63:0] w;
        logic [3:0]  kind;
        w = {$urandom, $urandom};
        kind = 4'($urandom_range(15));
        if ($urandom_range(1))
            return '1;
        // step past the decoded types
        if (kind >= TYPE_END && kind <= TYPE_HIT)
            kind = kind + 4'd3;
        w[63:60] = kind;
        return w;
    endfunction

    task automatic clear_event_state();
        header_seen = 1'b0;
        held_event_time = '0;
        held_trigger_number = '0;
        pending_count = 0;
        drop_flag = 1'b0;
    endtask

    task automatic predict_word(input logic [63:0] w);
        logic [3:0]     kind;
        logic [8:0]     r;
        logic [9:0]     tot_bin;
        logic [39:0]    trig_t;
        logic [9:0]     cts;
        logic [PIW-1:0] slot;
        hit_out_t       o;
        int             n_emit;
        int             seq;
        kind = w[63:60];
        if (w == '1)
            return;
        if (kind == TYPE_HEADER)
        begin
            held_event_time = w[39:0];
            held_trigger_number = w[59:40];
            header_seen = 1'b1;
        end
        else if (kind == TYPE_HIT)
        begin
            r = ~{w[16], w[15:8]};
            if (r < ROW_FOLD)
                r = ROW_MIRROR - r;
            if (w[7:0] <= COL_MAX && r < ROW_LIMIT)
            begin
                if (pending_count >= MAX_PENDING_DEF)
                    drop_flag = 1'b1;
                else
                begin
                    slot = pending_count[PIW-1:0];
                    tot_bin = gray_to_binary({3'b000, ~w[23:17]});
                    pending_hits[slot].column = COL_MAX - w[7:0];
                    pending_hits[slot].row = r;
                    pending_hits[slot].tot_code = tot_bin[6:0];
                    pending_hits[slot].begin_flag = w[59];
                    pending_hits[slot].after_header = header_seen;
                    pending_hits[slot].fine_time = w[55:24];
                    pending_hits[slot].event_time = held_event_time;
                    pending_hits[slot].trigger_number = held_trigger_number;
                    pending_count++;
                end
            end
        end
        else if (kind == TYPE_END)
        begin
            trig_t = {w[57:56], w[55:24], w[23:18]};
            cts = gray_to_binary(w[9:0]);
            n_emit = 0;
            for (int i = 0; i < pending_count; i++)
            begin
                if (pending_hits[i[PIW-1:0]].after_header)
                    n_emit++;
            end
            seq = 0;
            for (int i = 0; i < pending_count; i++)
            begin
                slot = i[PIW-1:0];
                if (pending_hits[slot].after_header)
                begin
                    o.column = pending_hits[slot].column;
                    o.row = pending_hits[slot].row;
                    o.tot_code = pending_hits[slot].tot_code;
                    o.fine_time = pending_hits[slot].fine_time;
                    o.begin_flag = pending_hits[slot].begin_flag;
                    o.event_time = pending_hits[slot].event_time;
                    o.trigger_number = pending_hits[slot].trigger_number;
                    o.trigger_time = trig_t;
                    o.coarse_ts = cts;
                    o.overflowed = drop_flag;
                    o.last = (seq == n_emit - 1);
                    expected_hits = {expected_hits, o};
                    seq++;
                end
            end
            if (n_emit > 0)
            begin
                events_closed++;
                if (drop_flag)
                    overflow_events++;
            end
            clear_event_state();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        hit_out_t exp_h;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected hit item, expected none, got column %0h row %0h",
                         $time, column, row);
                error_count++;
            end
            else
            begin
                exp_h = expected_hits.pop_front();
                check_field("column", 64'(exp_h.column), 64'(column));
                check_field("row", 64'(exp_h.row), 64'(row));
                check_field("tot_code", 64'(exp_h.tot_code), 64'(tot_code));
                check_field("fine_time", 64'(exp_h.fine_time), 64'(fine_time));
                check_field("begin_flag", 64'(exp_h.begin_flag), 64'(begin_flag));
                check_field("event_time", 64'(exp_h.event_time), 64'(event_time));
                check_field("trigger_number", 64'(exp_h.trigger_number),
                            64'(trigger_number));
                check_field("trigger_time", 64'(exp_h.trigger_time), 64'(trigger_time));
                check_field("coarse_ts", 64'(exp_h.coarse_ts), 64'(coarse_ts));
                check_field("overflowed", 64'(exp_h.overflowed), 64'(overflowed));
                check_field("last", 64'(exp_h.last), 64'(last));
                hits_checked++;
            end
        end
    end

    task automatic send_word(input logic [63:0] w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_word(w);
        if (w != '1 && w[63:60] >= TYPE_END && w[63:60] <= TYPE_HIT)
            words_used++;
    endtask

    // hold the input off until every predicted hit has come out
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY) @(posedge clk);
    endtask

    task automatic test_directed();
        send_word({TYPE_END, 60'h0});
        // stored before any header, so never emitted
        send_word(hit_word(1'b0, 32'h1234_5678, 7'h2A, 9'd300, 8'd5));
        send_word('1);
        send_word({TYPE_NONE, 60'h0});
        send_word({TYPE_TEST, {15{4'hA}}});
        send_word({TYPE_FILL, 60'h0});
        send_word({TYPE_HEADER, 20'hFFFFF, 40'hFF_FFFF_FFFF});
        send_word(hit_word(1'b1, 32'hFFFF_FFFF, 7'h7F, 9'h1FF, 8'd0));
        send_word(hit_word(1'b0, 32'h0, 7'h00, RAW_ROW_OK, COL_MAX));
        send_word(hit_word(1'b1, $urandom, 7'h55, 9'd300, COL_MAX + 8'd1));
        send_word(hit_word(1'b0, $urandom, 7'h11, RAW_ROW_OK - 9'd1, 8'd10));
        send_word(hit_word(1'b0, $urandom, 7'h22, 9'd0, 8'd20));
        // row just at and just above the fold
        send_word(hit_word(1'b1, $urandom, 7'h33, 9'h1FF - ROW_MIRROR, 8'd30));
        send_word(hit_word(1'b1, $urandom, 7'h44, 9'h1FF - ROW_FOLD, 8'd40));
        send_word({TYPE_HEADER, 60'h0});
        send_word(hit_word(1'b0, $urandom, 7'h01, 9'd400, 8'd64));
        send_word({TYPE_END, 60'hFFF_FFFF_FFFF_FFFF});
        send_word(hit_word(1'b1, $urandom, 7'h0F, 9'd200, 8'd99));
        send_word(make_end());
        send_word(make_header());
        send_word({TYPE_END, 60'h5A5_A5A5_A5A5_A5A5});
    endtask

    task automatic test_random_events(input int n_words);
        int target;
        int n_hits;
        int pick;
        target = words_used + n_words;
        while (words_used < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if ($urandom_range(9) == 0)
                    send_word(make_hit(1'b1));
                send_word(make_header());
                n_hits = ($urandom_range(19) == 0) ? $urandom_range(31, 20) : $urandom_range(8);
                for (int i = 0; i < n_hits; i++)
                begin
                    send_word(make_hit($urandom_range(7) != 0));
                    if ($urandom_range(11) == 0)
                        send_word(make_noise());
                    if ($urandom_range(14) == 0)
                        send_word(make_header());
                end
                send_word(make_end());
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(4, 1)) send_word(make_noise());
                send_word(make_hit(1'b0));
            end
            else if (pick < 90)
            begin
                if ($urandom_range(1))
                    send_word(make_hit(1'b1));
                send_word(make_end());
            end
            else
                send_word({$urandom, $urandom});
        end
    endtask

    task automatic test_overflow();
        send_word(make_header());
        repeat (MAX_PENDING_DEF + 4) send_word(make_hit(1'b1));
        send_word(make_end());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        word = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        error_count = 0;
        words_used = 0;
        hits_checked = 0;
        events_closed = 0;
        overflow_events = 0;
        clear_event_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();

        send_idle_pct = 21;
        recv_idle_pct = 50;
        test_random_events(60);
        test_overflow();

        send_idle_pct = 50;
        recv_idle_pct = 21;
        test_random_events(30);
        drain_results();
        test_random_events(30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_events(55);

        drain_results();
        if (expected_hits.size() != 0)
        begin
            $display("%0t: %0d hit items never came out", $time, expected_hits.size());
            error_count++;
        end
        $display("covered %0d decoded words and %0d checked hits over %0d events",
                 words_used, hits_checked, events_closed);
        $display("%0d events overflowed the pending store, %0d errors",
                 overflow_events, error_count);
        if (error_count == 0)
            $display("[triggered_hit_event_builder] OK");
        else
            $display("[triggered_hit_event_builder] ERROR");
        $finish;
    end

endmodule
